// ===== design/spq_pkg.sv =====
package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int PRI_W        = 8;
    localparam int COUNT_OUT_W  = 5;
    localparam int IN_DATA_W    = 40;
    localparam int OUT_DATA_W   = 48;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPRI = 2'd3
    } t_status;

    typedef enum logic {
        REQ_ENQ = 1'b0,
        REQ_DEQ = 1'b1
    } t_req;

    // operation broadcast to every cell of the chain
    typedef struct packed {
        logic               enq;
        logic               deq;
        logic [VALUE_W-1:0] value;
        logic [PRI_W-1:0]   pri;
    } t_cell_ctl;

endpackage

// ===== design/spq_cell.sv =====
module spq_cell
    import spq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_occ,
    input  t_cell_ctl          i_ctl,
    input  logic               i_left_ge,
    input  logic [VALUE_W-1:0] i_left_value,
    input  logic [PRI_W-1:0]   i_left_pri,
    input  logic [VALUE_W-1:0] i_right_value,
    input  logic [PRI_W-1:0]   i_right_pri,
    output logic               o_ge,
    output logic [VALUE_W-1:0] o_value,
    output logic [PRI_W-1:0]   o_pri
);

    logic [VALUE_W-1:0] r_value;
    logic [PRI_W-1:0]   r_pri;
    logic [VALUE_W-1:0] n_value;
    logic [PRI_W-1:0]   n_pri;

    // entry stays ahead of a new item of equal or lower priority
    assign o_ge    = i_occ && (r_pri >= i_ctl.pri);
    assign o_value = r_value;
    assign o_pri   = r_pri;

    always_comb begin
        n_value = r_value;
        n_pri   = r_pri;
        if (i_ctl.enq && !o_ge) begin
            if (i_left_ge) begin
                n_value = i_ctl.value;
                n_pri   = i_ctl.pri;
            end else begin
                n_value = i_left_value;
                n_pri   = i_left_pri;
            end
        end else if (i_ctl.deq) begin
            n_value = i_right_value;
            n_pri   = i_right_pri;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_pri   <= n_pri;
    end

endmodule

// ===== design/sorted_priority_queue.sv =====
// result: registered, on the master side in the cycle after the input transfer
// throughput: one enqueue or dequeue per cycle while the master side takes the results; on enqueue the
// cells behind the insertion point, on dequeue all cells, shift or load in the same cycle as the request is taken
// reset: synchronous active low, clears the entry count and the result valid,
// entry contents are undefined until written
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // item_value, item_priority
    input  logic                  i_s_tuser,   // req_type
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // out_value, out_priority, entry_count, zero pad
    output logic [1:0]            o_m_tuser    // status
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_out_valid;
    t_status            r_status;
    logic [VALUE_W-1:0] r_out_value;
    logic [PRI_W-1:0]   r_out_pri;
    logic [CW-1:0]      r_out_count;

    logic               accept;
    logic               full;
    logic               empty;
    logic [VALUE_W-1:0] in_value;
    logic [PRI_W-1:0]   in_pri;
    t_cell_ctl          ctl;
    t_status            status;

    logic [CAPACITY-1:0] occ;
    logic [CAPACITY-1:0] ge;
    logic [VALUE_W-1:0]  cell_value [CAPACITY];
    logic [PRI_W-1:0]    cell_pri   [CAPACITY];
    logic [CW+COUNT_OUT_W-1:0] count_ext;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign in_value   = i_s_tdata[VALUE_W-1:0];
    assign in_pri     = i_s_tdata[VALUE_W+PRI_W-1:VALUE_W];
    assign full       = (r_count == CW'(CAPACITY));
    assign empty      = (r_count == '0);

    always_comb begin
        ctl.enq   = 1'b0;
        ctl.deq   = 1'b0;
        ctl.value = in_value;
        ctl.pri   = in_pri;
        status    = ST_OK;
        n_count   = r_count;
        if (t_req'(i_s_tuser) == REQ_ENQ) begin
            if (full) begin
                status = ST_FULL;
            end else if (in_pri == '0) begin
                status = ST_BADPRI;
            end else begin
                ctl.enq = accept;
                if (accept) begin
                    n_count = r_count + 1'b1;
                end
            end
        end else begin
            if (empty) begin
                status = ST_EMPTY;
            end else begin
                ctl.deq = accept;
                if (accept) begin
                    n_count = r_count - 1'b1;
                end
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic               left_ge;
            logic [VALUE_W-1:0] left_value;
            logic [PRI_W-1:0]   left_pri;
            logic [VALUE_W-1:0] right_value;
            logic [PRI_W-1:0]   right_pri;

            assign occ[gi] = (r_count > CW'(gi));

            if (gi == 0) begin : g_head
                assign left_ge    = 1'b1;
                assign left_value = '0;
                assign left_pri   = '0;
            end else begin : g_body
                assign left_ge    = ge[gi-1];
                assign left_value = cell_value[gi-1];
                assign left_pri   = cell_pri[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign right_value = '0;
                assign right_pri   = '0;
            end else begin : g_mid
                assign right_value = cell_value[gi+1];
                assign right_pri   = cell_pri[gi+1];
            end

            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_occ         (occ[gi]),
                .i_ctl         (ctl),
                .i_left_ge     (left_ge),
                .i_left_value  (left_value),
                .i_left_pri    (left_pri),
                .i_right_value (right_value),
                .i_right_pri   (right_pri),
                .o_ge          (ge[gi]),
                .o_value       (cell_value[gi]),
                .o_pri         (cell_pri[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= status;
            r_out_count <= n_count;
            if (ctl.deq) begin
                r_out_value <= cell_value[0];
                r_out_pri   <= cell_pri[0];
            end else begin
                r_out_value <= '0;
                r_out_pri   <= '0;
            end
        end
    end

    // low bits of the count only
    assign count_ext = {{COUNT_OUT_W{1'b0}}, r_out_count};

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {{(OUT_DATA_W - VALUE_W - PRI_W - COUNT_OUT_W){1'b0}},
                         count_ext[COUNT_OUT_W-1:0], r_out_pri, r_out_value};

endmodule
